// File: design/rsa_modexp_engine_core_defines.svh
// ----------------------------------------------------------------------------
// RSA modexp engine assertion macros
// Shared concurrent assertion forms used by the engine's modules.
// ----------------------------------------------------------------------------
`ifndef RSA_MODEXP_ENGINE_CORE_DEFINES_SVH
`define RSA_MODEXP_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RME_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RME_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rme_pkg.sv
// ----------------------------------------------------------------------------
// RSA modexp engine package
// Shared widths, register and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int DATA_W       = 32;
    localparam int MOD_BITS_DEF = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP  = CFG_IDX_W'(2);

    localparam logic REQ_DECRYPT      = 1'b1;
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_RANGE_ERR = 1'b1;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic mul_square;
        logic exp_shift;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic range_err;
        logic exp_zero;
        logic exp_lsb;
        logic exp_last;
        logic mul_busy;
        logic mul_done;
    } t_dp_status;

endpackage

// File: design/rme_modmul.sv
// ----------------------------------------------------------------------------
// RSA modexp engine modular multiplier
// Bit-serial interleaved (a * b) mod m, one bit of a per cycle, MSB first.
// ----------------------------------------------------------------------------
`include "rsa_modexp_engine_core_defines.svh"

module rme_modmul #(
    parameter int MOD_BITS = rme_pkg::MOD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_a,
    input  logic [MOD_BITS-1:0] i_b,
    input  logic [MOD_BITS-1:0] i_m,
    output logic                o_busy,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_p
);

    localparam int CW = $clog2(MOD_BITS + 1);
    localparam int EW = MOD_BITS + 2;

    logic [MOD_BITS-1:0] r_a;
    logic [MOD_BITS-1:0] r_b;
    logic [MOD_BITS-1:0] r_r;
    logic [MOD_BITS-1:0] n_r;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [EW-1:0] w_dbl;
    logic [EW-1:0] w_sum;
    logic [EW-1:0] w_m1;
    logic [EW-1:0] w_m2;

    // Doubling and the optional add of b are folded into one step: the
    // partial value stays below 3m, so one of three candidates lies in [0, m).
    always_comb begin
        w_dbl = {1'b0, r_r, 1'b0};
        w_sum = w_dbl + {2'b00, r_b};
        w_m1  = {2'b00, i_m};
        w_m2  = {1'b0, i_m, 1'b0};
        if (r_a[MOD_BITS-1]) begin
            if (w_sum >= w_m2) begin
                n_r = MOD_BITS'(w_sum - w_m2);
            end else if (w_sum >= w_m1) begin
                n_r = MOD_BITS'(w_sum - w_m1);
            end else begin
                n_r = MOD_BITS'(w_sum);
            end
        end else begin
            if (w_dbl >= w_m1) begin
                n_r = MOD_BITS'(w_dbl - w_m1);
            end else begin
                n_r = MOD_BITS'(w_dbl);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_r   <= '0;
            r_cnt <= CW'(MOD_BITS);
        end else if (r_busy) begin
            r_a   <= r_a << 1;
            r_r   <= n_r;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_p    = r_r;

    `RME_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_start, r_busy && (r_cnt == CW'(MOD_BITS)), "multiplier did not start a full pass")
    `RME_ASSERT_NEXT(a_last_done, i_clk, i_rst_n, r_busy && (r_cnt == CW'(1)) && !i_start, r_done && !r_busy, "multiplier missed its done pulse")
    `RME_ASSERT_IMPL(a_busy_cnt, i_clk, i_rst_n, r_busy, r_cnt != '0, "multiplier busy with an empty bit count")

endmodule

// File: design/rme_datapath.sv
// ----------------------------------------------------------------------------
// RSA modexp engine datapath
// Key registers, base/accumulator/exponent registers, multiplier, result beat.
// ----------------------------------------------------------------------------
module rme_datapath #(
    parameter int MOD_BITS = rme_pkg::MOD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rme_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rme_pkg::DATA_W-1:0]     i_cfg_wdata,
    input  logic                           i_req_type,
    input  logic [rme_pkg::DATA_W-1:0]     i_value_in,
    input  rme_pkg::t_dp_cmd               i_cmd,
    output rme_pkg::t_dp_status            o_sts,
    output logic [rme_pkg::DATA_W-1:0]     o_value_out,
    output logic                           o_status
);

    logic [MOD_BITS-1:0] r_modulus;
    logic [MOD_BITS-1:0] r_pub_exp;
    logic [MOD_BITS-1:0] r_priv_exp;
    logic [MOD_BITS-1:0] r_base;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_exp;
    logic                r_err;
    logic                r_dst_acc;
    logic [rme_pkg::DATA_W-1:0] r_value_out;
    logic                r_status;

    logic [MOD_BITS-1:0] w_val;
    logic [MOD_BITS-1:0] w_cfg;
    logic [MOD_BITS-1:0] w_mul_a;
    logic [MOD_BITS-1:0] w_prod;
    logic                w_mul_busy;
    logic                w_mul_done;

    assign w_val   = MOD_BITS'(i_value_in);
    assign w_cfg   = MOD_BITS'(i_cfg_wdata);
    assign w_mul_a = i_cmd.mul_square ? r_base : r_acc;

    rme_modmul #(
        .MOD_BITS (MOD_BITS)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (r_base),
        .i_m     (r_modulus),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done),
        .o_p     (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= '0;
            r_pub_exp  <= '0;
            r_priv_exp <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rme_pkg::CFG_MODULUS:  r_modulus  <= w_cfg;
                rme_pkg::CFG_PUB_EXP:  r_pub_exp  <= w_cfg;
                rme_pkg::CFG_PRIV_EXP: r_priv_exp <= w_cfg;
                default: ;
            endcase
        end
    end

    // A modulus of one sends every power to zero, including exponent zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= w_val;
            r_exp  <= (i_req_type == rme_pkg::REQ_DECRYPT) ? r_priv_exp : r_pub_exp;
            r_acc  <= (r_modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
            r_err  <= (r_modulus == '0) || (w_val >= r_modulus);
        end else begin
            if (i_cmd.exp_shift) begin
                r_exp <= r_exp >> 1;
            end
            if (w_mul_done) begin
                if (r_dst_acc) begin
                    r_acc <= w_prod;
                end else begin
                    r_base <= w_prod;
                end
            end
        end
        if (i_cmd.mul_start) begin
            r_dst_acc <= !i_cmd.mul_square;
        end
        if (i_cmd.out_load) begin
            r_value_out <= r_err ? '0 : rme_pkg::DATA_W'(r_acc);
            r_status    <= r_err ? rme_pkg::STATUS_RANGE_ERR : rme_pkg::STATUS_OK;
        end
    end

    always_comb begin
        o_sts.range_err = r_err;
        o_sts.exp_zero  = (r_exp == '0);
        o_sts.exp_lsb   = r_exp[0];
        o_sts.exp_last  = ((r_exp >> 1) == '0);
        o_sts.mul_busy  = w_mul_busy;
        o_sts.mul_done  = w_mul_done;
    end

    assign o_value_out = r_value_out;
    assign o_status    = r_status;

endmodule

// File: design/rme_ctrl.sv
// ----------------------------------------------------------------------------
// RSA modexp engine controller
// Sequences square-and-multiply over the exponent and hands off result beats.
// ----------------------------------------------------------------------------
`include "rsa_modexp_engine_core_defines.svh"

module rme_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  rme_pkg::t_dp_status i_sts,
    output rme_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MUL_ACC,
        S_MUL_SQ,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.range_err || i_sts.exp_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_start  = 1'b1;
                    o_cmd.mul_square = !i_sts.exp_lsb;
                    n_state          = i_sts.exp_lsb ? S_MUL_ACC : S_MUL_SQ;
                end
            end
            S_MUL_ACC: begin
                // The last squaring is not needed once the exponent runs out.
                if (i_sts.mul_done) begin
                    if (i_sts.exp_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.mul_start  = 1'b1;
                        o_cmd.mul_square = 1'b1;
                        n_state          = S_MUL_SQ;
                    end
                end
            end
            S_MUL_SQ: begin
                o_cmd.exp_shift = i_sts.mul_done;
                if (i_sts.mul_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DONE: begin
                o_cmd.out_load = !r_out_valid || i_out_ready;
                if (o_cmd.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `RME_ASSERT_IMPL(a_idle_mul_quiet, i_clk, i_rst_n, r_state == S_IDLE, !i_sts.mul_busy, "multiplier busy while idle")
    `RME_ASSERT_IMPL(a_start_free, i_clk, i_rst_n, o_cmd.mul_start, !i_sts.mul_busy, "multiplication started on a busy unit")
    `RME_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, o_cmd.out_load, o_out_valid && (r_state == S_IDLE), "result beat not presented after load")

endmodule

// File: design/rsa_modexp_engine_core.sv
// ----------------------------------------------------------------------------
// RSA modexp engine core
// Computes value^exponent mod modulus with a square-and-multiply sequencer.
// ----------------------------------------------------------------------------
// Usage: software writes the modulus, public and private exponents through
// the write port (index 0, 1, 2) while the engine is idle. A request beat
// carries req_type (encrypt with the public exponent, decrypt with the
// private one) and value_in; each request yields one result beat with
// value_out and status. A value not below the modulus, or any value with
// a zero modulus, returns status 1 and value_out 0; that result beat goes
// through the decide and done states without any multiplication.
// Each modular multiplication runs on the single bit-serial multiplier;
// an exponent with k significant bits and w set bits costs k + w - 1
// multiplications, plus a decide step for each exponent bit. One request
// is processed at a time; the next one is taken as soon as the result sits
// in the output register, even if the receiver has not yet taken it. A
// stalled receiver holds the result beat, and a finished computation waits
// until that register frees. Reset clears the key registers to zero and
// drops any request or result in flight.
// ----------------------------------------------------------------------------
module rsa_modexp_engine_core #(
    parameter int MOD_BITS = rme_pkg::MOD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rme_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rme_pkg::DATA_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [rme_pkg::DATA_W-1:0]    i_value_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rme_pkg::DATA_W-1:0]    o_value_out,
    output logic                          o_status
);

    rme_pkg::t_dp_cmd    w_cmd;
    rme_pkg::t_dp_status w_sts;

    rme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rme_datapath #(
        .MOD_BITS (MOD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_type  (i_req_type),
        .i_value_in  (i_value_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_value_out (o_value_out),
        .o_status    (o_status)
    );

endmodule

// File: dv/rsa_modexp_engine_core_tb.sv
// ----------------------------------------------------------------------------
// RSA modexp engine core testbench
// Programs the modulus and both exponents between phases and sends encrypt
// and decrypt requests. A directed table covers the reset state, the modulus
// extremes, exponent zero and out-of-range values. Random phases follow, with
// random gaps on the request side and random stalls on the result side. Every
// result beat is checked against a typed value or a square-and-multiply prediction.
// ----------------------------------------------------------------------------
module rsa_modexp_engine_core_tb;

    localparam int          DATA_W        = rme_pkg::DATA_W;
    localparam int          CFG_IDX_W     = rme_pkg::CFG_IDX_W;
    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 8;
    localparam int          TOTAL_ITEMS   = 280;
    localparam int          QUIET_ITEMS   = 40;
    localparam int          SETTLE_CYCLES = 2200;
    localparam longint      CYCLE_LIMIT   = 4000000;
    localparam logic        REQ_ENCRYPT   = ~rme_pkg::REQ_DECRYPT;
    // Index 3 is past the key registers; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
    localparam bit          NEW_KEYS      = 1'b1;
    localparam bit          KEEP_KEYS     = 1'b0;
    localparam bit          TYPED         = 1'b1;
    localparam bit          PREDICTED     = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              status;
    } t_rsa_result;

    typedef struct packed {
        bit                set_keys;
        logic [DATA_W-1:0] modulus;
        logic [DATA_W-1:0] pub_exp;
        logic [DATA_W-1:0] priv_exp;
        logic              req_type;
        logic [DATA_W-1:0] value;
        bit                typed;
        t_rsa_result       want;
    } t_directed_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_req_type  = 1'b0;
    logic [DATA_W-1:0]    i_value_in  = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [DATA_W-1:0]    o_value_out;
    logic                 o_status;

    logic [DATA_W-1:0] key_modulus = '0;
    logic [DATA_W-1:0] key_pub_exp = '0;
    logic [DATA_W-1:0] key_priv_exp = '0;

    t_rsa_result   expected_results [$];
    t_directed_row directed_rows [$];
    int            error_count = 0;
    int            items_sent  = 0;
    longint        cycle_count = 0;
    bit            quiet_tail  = 1'b0;

    rsa_modexp_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_value_in  (i_value_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value_out (o_value_out),
        .o_status    (o_status)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // Right-to-left square-and-multiply; 64-bit products cannot overflow.
    function automatic t_rsa_result modexp_predict(input logic rtype,
                                                   input logic [DATA_W-1:0] val);
        longint unsigned m;
        longint unsigned base;
        longint unsigned acc;
        longint unsigned ex;
        t_rsa_result     r;
        m  = key_modulus;
        ex = (rtype == rme_pkg::REQ_DECRYPT) ? key_priv_exp : key_pub_exp;
        if (m == 0 || val >= m) begin
            r.value  = '0;
            r.status = rme_pkg::STATUS_RANGE_ERR;
            return r;
        end
        acc  = 1 % m;
        base = val;
        while (ex != 0) begin
            if (ex[0]) begin
                acc = (acc * base) % m;
            end
            base = (base * base) % m;
            ex   = ex >> 1;
        end
        r.value  = acc[DATA_W-1:0];
        r.status = rme_pkg::STATUS_OK;
        return r;
    endfunction

    task automatic add_row(input bit set_keys, input logic [DATA_W-1:0] m,
                           input logic [DATA_W-1:0] e, input logic [DATA_W-1:0] d,
                           input logic rtype, input logic [DATA_W-1:0] val,
                           input bit typed, input logic [DATA_W-1:0] want_value,
                           input logic want_status);
        t_directed_row row;
        row.set_keys    = set_keys;
        row.modulus     = m;
        row.pub_exp     = e;
        row.priv_exp    = d;
        row.req_type    = rtype;
        row.value       = val;
        row.typed       = typed;
        row.want.value  = want_value;
        row.want.status = want_status;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Lowers valid right after the last accepted beat and waits for the
    // engine to hand back everything in flight.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic program_keys(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] e,
                                input logic [DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rme_pkg::CFG_MODULUS;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_index <= rme_pkg::CFG_PUB_EXP;
        i_cfg_wdata <= e;
        @(posedge i_clk);
        i_cfg_index <= rme_pkg::CFG_PRIV_EXP;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_wdata <= $urandom;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        key_modulus  = m;
        key_pub_exp  = e;
        key_priv_exp = d;
    endtask

    task automatic send_request(input logic rtype, input logic [DATA_W-1:0] val,
                                input t_rsa_result want);
        int gap;
        if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rtype;
        i_value_in <= val;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        expected_results.insert(expected_results.size(), want);
        items_sent++;
    endtask

    function automatic logic [DATA_W-1:0] pick_exponent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return DATA_W'($urandom_range(1, 64));
            default: return $urandom;
        endcase
    endfunction

    // Result side: long ready stretches mixed with short stall bursts.
    initial begin
        int run;
        @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 3000)
                                              : $urandom_range(1, 16);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 1) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsa_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: value_out %h status %b",
                       o_value_out, o_status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_value_out !== want.value) begin
                    $error("value_out: expected %h, got %h", want.value, o_value_out);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %b, got %b", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[rsa_modexp_engine_core] ERROR");
            $finish;
        end
    end

    initial begin
        t_directed_row     row;
        t_rsa_result       want;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] val;
        logic              rtype;
        int                phase_len;

        // Reset state: modulus is zero, so every request is out of range.
        add_row(KEEP_KEYS, '0, '0, '0, REQ_ENCRYPT, '0, TYPED, '0,
                rme_pkg::STATUS_RANGE_ERR);
        add_row(KEEP_KEYS, '0, '0, '0, rme_pkg::REQ_DECRYPT, '1, TYPED, '0,
                rme_pkg::STATUS_RANGE_ERR);
        // Modulus one reduces every in-range result to zero, exponent zero too.
        add_row(NEW_KEYS, 32'd1, '0, 32'd5, REQ_ENCRYPT, '0, TYPED, '0, rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, rme_pkg::REQ_DECRYPT, '0, TYPED, '0,
                rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, REQ_ENCRYPT, 32'd1, TYPED, '0,
                rme_pkg::STATUS_RANGE_ERR);
        // Widest modulus, exponent zero on encrypt and all ones on decrypt.
        add_row(NEW_KEYS, '1, '0, '1, REQ_ENCRYPT, '0, TYPED, 32'd1, rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, REQ_ENCRYPT, 32'hFFFF_FFFE, TYPED, 32'd1,
                rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, REQ_ENCRYPT, '1, TYPED, '0,
                rme_pkg::STATUS_RANGE_ERR);
        add_row(KEEP_KEYS, '0, '0, '0, rme_pkg::REQ_DECRYPT, '0, TYPED, '0,
                rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, rme_pkg::REQ_DECRYPT, 32'd1, TYPED, 32'd1,
                rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, rme_pkg::REQ_DECRYPT, 32'hFFFF_FFFE, TYPED,
                32'hFFFF_FFFE, rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, rme_pkg::REQ_DECRYPT, 32'h1234_5678, PREDICTED, '0,
                rme_pkg::STATUS_OK);
        // Small textbook key pair: encrypt and decrypt round trip.
        add_row(NEW_KEYS, 32'd3233, 32'd17, 32'd2753, REQ_ENCRYPT, 32'd65, TYPED,
                32'd2790, rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, rme_pkg::REQ_DECRYPT, 32'd2790, TYPED, 32'd65,
                rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, REQ_ENCRYPT, 32'd3232, PREDICTED, '0,
                rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, rme_pkg::REQ_DECRYPT, 32'd3233, TYPED, '0,
                rme_pkg::STATUS_RANGE_ERR);
        // Power-of-two modulus, value just below and at the modulus.
        add_row(NEW_KEYS, 32'h8000_0000, 32'd3, '1, REQ_ENCRYPT, 32'h7FFF_FFFF, PREDICTED,
                '0, rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, rme_pkg::REQ_DECRYPT, 32'h7FFF_FFFF, PREDICTED, '0,
                rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, REQ_ENCRYPT, 32'h8000_0000, TYPED, '0,
                rme_pkg::STATUS_RANGE_ERR);
        // Largest 32-bit prime with the usual public exponent.
        add_row(NEW_KEYS, 32'hFFFF_FFFB, 32'd65537, 32'hDEAD_BEEF, REQ_ENCRYPT,
                32'hFFFF_FFFA, PREDICTED, '0, rme_pkg::STATUS_OK);
        add_row(KEEP_KEYS, '0, '0, '0, rme_pkg::REQ_DECRYPT, 32'hA5A5_5A5A, PREDICTED, '0,
                rme_pkg::STATUS_OK);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.set_keys) begin
                drain_results();
                program_keys(row.modulus, row.pub_exp, row.priv_exp);
            end
            want = row.typed ? row.want : modexp_predict(row.req_type, row.value);
            send_request(row.req_type, row.value, want);
        end

        while (items_sent < TOTAL_ITEMS) begin
            drain_results();
            case ($urandom_range(0, 9))
                0:       m = '0;
                1:       m = 32'd1;
                2:       m = '1;
                3:       m = DATA_W'(1) << $urandom_range(1, DATA_W - 1);
                4, 5:    m = DATA_W'($urandom_range(2, 5000));
                default: m = $urandom;
            endcase
            program_keys(m, pick_exponent(), pick_exponent());
            phase_len = $urandom_range(8, 30);
            repeat (phase_len) begin
                if (items_sent < TOTAL_ITEMS) begin
                    quiet_tail = (items_sent >= TOTAL_ITEMS - QUIET_ITEMS);
                    rtype      = 1'($urandom_range(0, 1));
                    if (m != 0 && $urandom_range(0, 9) < 8) begin
                        val = $urandom % m;
                    end else begin
                        case ($urandom_range(0, 3))
                            0:       val = m;
                            1:       val = '1;
                            2:       val = m - 1;
                            default: val = $urandom;
                        endcase
                    end
                    send_request(rtype, val, modexp_predict(rtype, val));
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[rsa_modexp_engine_core] OK");
        end else begin
            $display("[rsa_modexp_engine_core] ERROR");
        end
        $finish;
    end

endmodule
